// ===== hdl/hsd_pkg.sv =====
package hsd_pkg;

  localparam int unsigned StepW = 6;

  localparam logic [63:0] FnvOffset = 64'hcbf2_9ce4_8422_2325;
  localparam logic [8:0]  FnvPrimeLow = 9'h1b3;
  localparam int unsigned FnvPrimeShift = 40;
  localparam logic [63:0] MixGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] SaltAdd = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MixMul1 = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned MixShiftA = 30;
  localparam int unsigned MixShiftB = 27;
  localparam int unsigned MixShiftC = 31;
  localparam int unsigned FracShift = 40;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_GAMMA,
    OP_XS30,
    OP_XS27,
    OP_XS31,
    OP_SALT,
    OP_XS31X,
    OP_MLL,
    OP_MLH,
    OP_MHL,
    OP_EMIT
  } op_e;

  typedef enum logic {
    K_MUL1,
    K_MUL2
  } ksel_e;

  typedef struct packed {
    op_e   op;
    ksel_e ksel;
    logic  skip_salt;
  } ctl_t;

  localparam logic [StepW-1:0] StepEmit = StepW'(32);

  function automatic ctl_t mk(op_e op, ksel_e ksel, logic skip_salt);
    ctl_t w;
    w.op = op;
    w.ksel = ksel;
    w.skip_salt = skip_salt;
    return w;
  endfunction

  // Microprogram: unsalted seed, then optional salt mix and second finalize.
  function automatic ctl_t rom_word(logic [StepW-1:0] step);
    ctl_t w;
    unique case (step)
      6'd0:  w = mk(OP_LOAD,  K_MUL1, 1'b0);
      6'd1:  w = mk(OP_GAMMA, K_MUL1, 1'b0);
      6'd2:  w = mk(OP_XS30,  K_MUL1, 1'b0);
      6'd3:  w = mk(OP_MLL,   K_MUL1, 1'b0);
      6'd4:  w = mk(OP_MLH,   K_MUL1, 1'b0);
      6'd5:  w = mk(OP_MHL,   K_MUL1, 1'b0);
      6'd6:  w = mk(OP_XS27,  K_MUL1, 1'b0);
      6'd7:  w = mk(OP_MLL,   K_MUL2, 1'b0);
      6'd8:  w = mk(OP_MLH,   K_MUL2, 1'b0);
      6'd9:  w = mk(OP_MHL,   K_MUL2, 1'b0);
      6'd10: w = mk(OP_XS31,  K_MUL1, 1'b1);
      6'd11: w = mk(OP_SALT,  K_MUL1, 1'b0);
      6'd12: w = mk(OP_GAMMA, K_MUL1, 1'b0);
      6'd13: w = mk(OP_XS30,  K_MUL1, 1'b0);
      6'd14: w = mk(OP_MLL,   K_MUL1, 1'b0);
      6'd15: w = mk(OP_MLH,   K_MUL1, 1'b0);
      6'd16: w = mk(OP_MHL,   K_MUL1, 1'b0);
      6'd17: w = mk(OP_XS27,  K_MUL1, 1'b0);
      6'd18: w = mk(OP_MLL,   K_MUL2, 1'b0);
      6'd19: w = mk(OP_MLH,   K_MUL2, 1'b0);
      6'd20: w = mk(OP_MHL,   K_MUL2, 1'b0);
      6'd21: w = mk(OP_XS31X, K_MUL1, 1'b0);
      6'd22: w = mk(OP_GAMMA, K_MUL1, 1'b0);
      6'd23: w = mk(OP_XS30,  K_MUL1, 1'b0);
      6'd24: w = mk(OP_MLL,   K_MUL1, 1'b0);
      6'd25: w = mk(OP_MLH,   K_MUL1, 1'b0);
      6'd26: w = mk(OP_MHL,   K_MUL1, 1'b0);
      6'd27: w = mk(OP_XS27,  K_MUL1, 1'b0);
      6'd28: w = mk(OP_MLL,   K_MUL2, 1'b0);
      6'd29: w = mk(OP_MLH,   K_MUL2, 1'b0);
      6'd30: w = mk(OP_MHL,   K_MUL2, 1'b0);
      6'd31: w = mk(OP_XS31,  K_MUL1, 1'b0);
      6'd32: w = mk(OP_EMIT,  K_MUL1, 1'b0);
      default: w = mk(OP_NOP, K_MUL1, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/hsd_seq.sv =====
module hsd_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              with_salt_i,
  input  logic              out_free_i,
  output hsd_pkg::ctl_t     ctl_o,
  output logic              busy_o,
  output logic              emit_o
);

  logic [hsd_pkg::StepW-1:0] step_q, step_d;
  logic                      busy_q, busy_d;
  logic                      salt_q, salt_d;
  hsd_pkg::ctl_t             word;

  assign word = hsd_pkg::rom_word(step_q);

  always_comb begin
    ctl_o = word;
    if (!busy_q) begin
      ctl_o = hsd_pkg::mk(hsd_pkg::OP_NOP, hsd_pkg::K_MUL1, 1'b0);
    end
  end

  assign emit_o = busy_q && (word.op == hsd_pkg::OP_EMIT) && out_free_i;
  assign busy_o = busy_q;

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    salt_d = salt_q;
    priority if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
        salt_d = with_salt_i;
      end
    end else if (word.op == hsd_pkg::OP_EMIT) begin
      // hold on the emit step until the output register frees up
      if (out_free_i) begin
        busy_d = 1'b0;
      end
    end else if (word.skip_salt && !salt_q) begin
      step_d = hsd_pkg::StepEmit;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      salt_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      salt_q <= salt_d;
    end
  end

endmodule

// ===== hdl/hsd_dp.sv =====
module hsd_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hsd_pkg::ctl_t ctl_i,
  input  logic          in_acc_i,
  input  logic [7:0]    data_byte_i,
  input  logic          has_byte_i,
  input  logic          last_byte_i,
  input  logic [31:0]   salt_high_i,
  input  logic [31:0]   salt_low_i,
  input  logic          cfg_wr_en_i,
  input  logic [63:0]   cfg_wr_data_i,
  output logic [63:0]   result_o
);

  logic [63:0] hash_q, hash_d;
  logic [63:0] base_q;
  logic [63:0] salt_q;
  logic [63:0] v_q, v_d;
  logic [63:0] p_q, p_d;
  logic [63:0] sav_q, sav_d;
  logic [63:0] fold;
  logic [63:0] k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul;
  logic [63:0] hash_mul;

  assign fold = hash_q ^ {56'd0, data_byte_i};
  assign hash_mul = fold * {55'd0, hsd_pkg::FnvPrimeLow};

  always_comb begin
    hash_d = hash_q;
    if (in_acc_i && has_byte_i) begin
      hash_d = (fold << hsd_pkg::FnvPrimeShift) + hash_mul;
    end
    if (ctl_i.op == hsd_pkg::OP_LOAD) begin
      hash_d = hsd_pkg::FnvOffset;
    end
  end

  assign k = (ctl_i.ksel == hsd_pkg::K_MUL2) ? hsd_pkg::MixMul2 : hsd_pkg::MixMul1;

  // one 32x32 multiplier; a 64-bit product takes three passes
  always_comb begin
    mul_a = (ctl_i.op == hsd_pkg::OP_MHL) ? v_q[63:32] : v_q[31:0];
    mul_b = (ctl_i.op == hsd_pkg::OP_MLH) ? k[63:32] : k[31:0];
  end
  assign mul = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    v_d = v_q;
    p_d = p_q;
    sav_d = sav_q;
    unique case (ctl_i.op)
      hsd_pkg::OP_LOAD:  v_d = base_q ^ hash_q;
      hsd_pkg::OP_GAMMA: v_d = v_q + hsd_pkg::MixGamma;
      hsd_pkg::OP_XS30:  v_d = v_q ^ (v_q >> hsd_pkg::MixShiftA);
      hsd_pkg::OP_XS27:  v_d = v_q ^ (v_q >> hsd_pkg::MixShiftB);
      hsd_pkg::OP_XS31:  v_d = v_q ^ (v_q >> hsd_pkg::MixShiftC);
      hsd_pkg::OP_SALT: begin
        sav_d = v_q;
        v_d = salt_q + hsd_pkg::SaltAdd;
      end
      hsd_pkg::OP_XS31X: v_d = v_q ^ (v_q >> hsd_pkg::MixShiftC) ^ sav_q;
      hsd_pkg::OP_MLL:   p_d = mul;
      hsd_pkg::OP_MLH:   p_d = p_q + {mul[31:0], 32'd0};
      hsd_pkg::OP_MHL:   v_d = p_q + {mul[31:0], 32'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= hsd_pkg::FnvOffset;
      base_q <= '0;
    end else begin
      hash_q <= hash_d;
      if (cfg_wr_en_i) begin
        base_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    p_q <= p_d;
    sav_q <= sav_d;
    if (in_acc_i && last_byte_i) begin
      salt_q <= {salt_high_i, salt_low_i};
    end
  end

  assign result_o = v_q;

endmodule

// ===== hdl/hashed_seed_derivation_core.sv =====
// Derives a 64-bit seed from a domain string fed at most one byte per request,
// using a running FNV-1a hash mixed with the base seed by a splitmix64
// finalizer, plus an optional salt stage. A request that is not marked last
// is taken without stalling the input. A last request is followed by a
// microcoded finalize that runs on a single 32x32 multiplier, three passes
// per 64-bit product, after which the result sits in the output register;
// input is stalled while it runs and for any wait on a full output register.
// fraction_o is seed_o[63:40], the numerator over 16777216.
module hashed_seed_derivation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  input  logic        with_salt_i,
  input  logic [31:0] salt_high_i,
  input  logic [31:0] salt_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] seed_o,
  output logic [23:0] fraction_o,
  input  logic        cfg_wr_en_i,
  input  logic [63:0] cfg_wr_data_i
);

  hsd_pkg::ctl_t ctl;
  logic          busy;
  logic          emit;
  logic          in_acc;
  logic          start;
  logic          out_free;
  logic [63:0]   result;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   seed_q;

  assign in_stall_o = busy;
  assign in_acc = in_valid_i && !busy;
  assign start = in_acc && last_byte_i;
  assign out_free = !out_valid_q || !out_stall_i;

  hsd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .with_salt_i (with_salt_i),
    .out_free_i  (out_free),
    .ctl_o       (ctl),
    .busy_o      (busy),
    .emit_o      (emit)
  );

  hsd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .in_acc_i      (in_acc),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .last_byte_i   (last_byte_i),
    .salt_high_i   (salt_high_i),
    .salt_low_i    (salt_low_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .result_o      (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      seed_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign seed_o = seed_q;
  assign fraction_o = seed_q[63:hsd_pkg::FracShift];

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("last request did not start finalize");

  a_bytes_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_byte_i |=> !in_stall_o)
    else $error("plain byte request stalled the input");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && !in_stall_o)
    else $error("emit did not load result and release input");

endmodule

// ===== bench/hsd_seed_checker.sv =====
module hsd_seed_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  input  logic        with_salt_i,
  input  logic [31:0] salt_high_i,
  input  logic [31:0] salt_low_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] seed_i,
  input  logic [23:0] fraction_i,
  input  logic        cfg_wr_en_i,
  input  logic [63:0] cfg_wr_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          requests_o,
  output int          seeds_o,
  output int          salted_o
);

  localparam logic [63:0] HashBasis = 64'd14695981039346656037;
  localparam logic [63:0] HashPrime = 64'd1099511628211;
  localparam logic [63:0] Golden    = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] SaltBias  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MulFirst  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MulSecond = 64'h94d0_49bb_1331_11eb;

  typedef struct {
    logic [63:0] seed;
    logic [23:0] fraction;
  } seed_result_t;

  seed_result_t expected_seeds[$];
  logic [63:0]  domain_hash;
  logic [63:0]  cfg_seed;
  int           fails;
  int           requests;
  int           seeds_seen;
  int           salted_seen;

  function automatic logic [63:0] splitmix_finalize(input logic [63:0] v);
    logic [63:0] x;
    x = v + Golden;
    x = (x ^ (x >> 30)) * MulFirst;
    x = (x ^ (x >> 27)) * MulSecond;
    return x ^ (x >> 31);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    seed_result_t want;
    logic [63:0]  h;
    logic [63:0]  s;
    if (!rst_ni) begin
      expected_seeds.delete();
      domain_hash = HashBasis;
      cfg_seed    = '0;
      fails       = 0;
      requests    = 0;
      seeds_seen  = 0;
      salted_seen = 0;
    end else begin
      if (cfg_wr_en_i) begin
        cfg_seed = cfg_wr_data_i;
      end

      // retire the oldest expectation against the result leaving the block
      if (out_valid_i && !out_stall_i) begin
        if (expected_seeds.size() == 0) begin
          $error("unexpected seed 0x%016h fraction 0x%06h", seed_i, fraction_i);
          fails++;
        end else begin
          want = expected_seeds.pop_front();
          seeds_seen++;
          if (seed_i !== want.seed) begin
            $error("seed: expected 0x%016h, got 0x%016h", want.seed, seed_i);
            fails++;
          end
          if (fraction_i !== want.fraction) begin
            $error("fraction: expected 0x%06h, got 0x%06h", want.fraction, fraction_i);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        requests++;
        h = domain_hash;
        if (has_byte_i) begin
          h = (h ^ {56'd0, data_byte_i}) * HashPrime;
        end
        if (last_byte_i) begin
          s = splitmix_finalize(cfg_seed ^ h);
          if (with_salt_i) begin
            s = splitmix_finalize(s ^ splitmix_finalize({salt_high_i, salt_low_i} + SaltBias));
            salted_seen++;
          end
          want.seed     = s;
          want.fraction = s[63:40];
          expected_seeds.push_back(want);
          h = HashBasis;
        end
        domain_hash = h;
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_seeds.size();
    requests_o   <= requests;
    seeds_o      <= seeds_seen;
    salted_o     <= salted_seen;
  end

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 40;
  localparam int PhaseItems  = 350;
  localparam int HoldTicks   = 600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_byte;
  logic        with_salt;
  logic [31:0] salt_high;
  logic [31:0] salt_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] seed;
  logic [23:0] fraction;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  int fail_count;
  int pending_seeds;
  int request_count;
  int seed_count;
  int salted_count;
  int burst_left;
  int base_settings;
  int cycle_count = 0;
  logic hold_off_req;
  logic hold_off_done;

  hashed_seed_derivation_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .has_byte_i   (has_byte),
    .last_byte_i  (last_byte),
    .with_salt_i  (with_salt),
    .salt_high_i  (salt_high),
    .salt_low_i   (salt_low),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .seed_o       (seed),
    .fraction_o   (fraction),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data)
  );

  hsd_seed_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_byte_i  (data_byte),
    .has_byte_i   (has_byte),
    .last_byte_i  (last_byte),
    .with_salt_i  (with_salt),
    .salt_high_i  (salt_high),
    .salt_low_i   (salt_low),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .seed_i       (seed),
    .fraction_i   (fraction),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_seeds),
    .requests_o   (request_count),
    .seeds_o      (seed_count),
    .salted_o     (salted_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d seeds outstanding", cycle_count, pending_seeds);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  task automatic send_request(input logic [7:0] b, input logic has, input logic lst,
                              input logic salted, input logic [31:0] hi,
                              input logic [31:0] lo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= has;
    last_byte <= lst;
    with_salt <= salted;
    salt_high <= hi;
    salt_low  <= lo;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and let every expected seed come out before touching config
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_seeds != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic write_seed_cfg(input logic [63:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    base_settings++;
  endtask

  task automatic run_domains(input int target);
    int sent;
    int len;
    logic [31:0] hi;
    logic [31:0] lo;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      if ($urandom_range(0, 7) == 0) begin
        hi = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        lo = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      end else begin
        hi = $urandom;
        lo = $urandom;
      end
      for (int i = 0; i < len; i++) begin
        send_request(8'($urandom), $urandom_range(0, 9) != 0, i == len - 1,
                     1'($urandom), (i == len - 1) ? hi : $urandom,
                     (i == len - 1) ? lo : $urandom);
        sent++;
      end
    end
  endtask

  // receiver: windows of differing stall density, plus one long hold-off on request
  initial begin
    int mode;
    int span;
    int tick;
    out_stall <= 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk);
        if (hold_off_req && !hold_off_done) begin
          out_stall <= 1'b1;
          repeat (HoldTicks) @(posedge clk);
          hold_off_done = 1'b1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 8) < 5);
        endcase
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    data_byte   = '0;
    has_byte    = 1'b0;
    last_byte   = 1'b0;
    with_salt   = 1'b0;
    salt_high   = '0;
    salt_low    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    burst_left  = 0;
    base_settings = 1;
    hold_off_req  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty domains, salt extremes, single bytes, gaps without a byte
    send_request(8'h00, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0);
    send_request(8'h00, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0);
    send_request(8'hff, 1'b0, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_request(8'h00, 1'b1, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
    send_request(8'hff, 1'b1, 1'b1, 1'b1, 32'h0, 32'hffff_ffff);
    send_request(8'h61, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
    send_request(8'h62, 1'b1, 1'b0, 1'b1, 32'h1, 32'h2);
    send_request(8'hff, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_request(8'h63, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
    send_request(8'h64, 1'b1, 1'b1, 1'b1, 32'h0000_0007, 32'h0000_0003);
    send_request(8'h80, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0);
    send_request(8'h7f, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
    send_request(8'h00, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 32'h0);
    send_request(8'h01, 1'b1, 1'b1, 1'b1, 32'h0, 32'h1);
    send_request(8'h55, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
    send_request(8'haa, 1'b1, 1'b1, 1'b0, 32'h1234_5678, 32'h9abc_def0);
    send_request(8'h00, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0);
    send_request(8'h00, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 32'h0);
    drain();

    write_seed_cfg(64'hffff_ffff_ffff_ffff);
    hold_off_req = 1'b1;
    run_domains(PhaseItems);
    drain();
    write_seed_cfg({$urandom, $urandom});
    run_domains(PhaseItems);
    drain();
    write_seed_cfg(64'h1);
    run_domains(PhaseItems);
    drain();
    write_seed_cfg(64'h8000_0000_0000_0000);
    run_domains(PhaseItems);
    drain();
    write_seed_cfg({$urandom, $urandom});
    run_domains(PhaseItems);
    drain();

    $display("Ran %0d requests through %0d base seed settings; %0d seeds compared, %0d salted.",
             request_count, base_settings, seed_count, salted_count);
    $display("Output was held off for %0d cycles once to back up the input side.", HoldTicks);
    if (fail_count == 0 && pending_seeds == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hsd_pkg.sv
hdl/hsd_seq.sv
hdl/hsd_dp.sv
hdl/hashed_seed_derivation_core.sv
bench/hsd_seed_checker.sv
bench/tb.sv
